@@ rtl/dhb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual H-bridge drive package
// Shared constants, codes and types for the steering and drive bridge block.
// ----------------------------------------------------------------------------
package dhb_pkg;

	localparam int SAMPLE_WIDTH_DEF = 12;
	localparam int DUTY_W           = 12;
	localparam int DRIVE_DUTY_W     = 11;
	localparam int SPEED_W          = 8;
	localparam int CFG_W            = 12;

	localparam logic [1:0] REQ_CTRL = 2'd0;
	localparam logic [1:0] REQ_PWM  = 2'd1;
	localparam logic [1:0] REQ_RAMP = 2'd2;

	localparam logic [1:0] STEER_BRAKE = 2'd0;
	localparam logic [1:0] STEER_POS   = 2'd1;
	localparam logic [1:0] STEER_NEG   = 2'd2;

	localparam logic [1:0] DRIVE_STOP = 2'd0;
	localparam logic [1:0] DRIVE_FWD  = 2'd1;
	localparam logic [1:0] DRIVE_REV  = 2'd2;

	localparam logic CFG_DEADBAND = 1'b0;
	localparam logic CFG_PWM_TOP  = 1'b1;

	localparam logic [CFG_W-1:0]   DEADBAND_RST = 12'd100;
	localparam logic [CFG_W-1:0]   PWM_TOP_RST  = 12'd999;
	localparam logic [DUTY_W-1:0]  PWM_CNT_RST  = 12'd500;
	localparam logic [SPEED_W-1:0] SPEED_MID    = 8'd128;
	localparam logic [DUTY_W-1:0]  DUTY_MAX     = 12'hFFF;

	typedef struct packed {
		logic [1:0]              steer_mode;
		logic [DUTY_W-1:0]       steer_duty;
		logic [1:0]              drive_mode;
		logic [DRIVE_DUTY_W-1:0] drive_duty;
	} ctrl_calc_t;

	typedef struct packed {
		logic               steer_pin_a;
		logic               steer_pin_b;
		logic               drive_pin_a;
		logic               drive_pin_b;
		logic [1:0]         steer_direction;
		logic [1:0]         drive_direction;
		logic [SPEED_W-1:0] current_speed;
	} view_t;

endpackage

@@ rtl/dhb_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one tick request per transaction.
// ----------------------------------------------------------------------------
interface dhb_req_if #(
	parameter int SAMPLE_WIDTH = dhb_pkg::SAMPLE_WIDTH_DEF
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              req_type;
	logic [SAMPLE_WIDTH-1:0] position_sample;
	logic [7:0]              target_value;

	modport source (output valid, output req_type, output position_sample,
		output target_value, input ready);
	modport sink (input valid, input req_type, input position_sample,
		input target_value, output ready);
endinterface

@@ rtl/dhb_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the bridge pin levels and status.
// ----------------------------------------------------------------------------
interface dhb_res_if;
	logic       valid;
	logic       ready;
	logic       steer_pin_a;
	logic       steer_pin_b;
	logic       drive_pin_a;
	logic       drive_pin_b;
	logic [1:0] steer_direction;
	logic [1:0] drive_direction;
	logic [7:0] current_speed;

	modport source (output valid, output steer_pin_a, output steer_pin_b,
		output drive_pin_a, output drive_pin_b, output steer_direction,
		output drive_direction, output current_speed, input ready);
	modport sink (input valid, input steer_pin_a, input steer_pin_b,
		input drive_pin_a, input drive_pin_b, input steer_direction,
		input drive_direction, input current_speed, output ready);
endinterface

@@ rtl/dhb_ctrl_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Control tick calculation
// Steering error, deadband test and duty, plus drive direction and duty.
// ----------------------------------------------------------------------------
module dhb_ctrl_calc #(
	parameter int SAMPLE_WIDTH = dhb_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic [SAMPLE_WIDTH-1:0]          sample,
	input  logic [7:0]                       target,
	input  logic [dhb_pkg::CFG_W-1:0]        deadband,
	input  logic [dhb_pkg::SPEED_W-1:0]      speed,
	input  logic [dhb_pkg::DUTY_W-1:0]       steer_duty,
	output dhb_pkg::ctrl_calc_t              calc
);
	localparam int EW = ((SAMPLE_WIDTH > dhb_pkg::DUTY_W) ? SAMPLE_WIDTH : dhb_pkg::DUTY_W) + 1;

	logic signed [EW-1:0] err;
	logic signed [EW-1:0] db;
	logic [EW-1:0]        mag;
	logic [7:0]           rev_off;

	always_comb begin
		err = $signed(EW'({target, 4'b0000})) - $signed(EW'(sample));
		db  = $signed(EW'(deadband));
		mag = '0;
		calc.steer_duty = steer_duty;
		if (err > db) begin
			calc.steer_mode = dhb_pkg::STEER_POS;
			mag = EW'(err);
		end else if (err < -db) begin
			calc.steer_mode = dhb_pkg::STEER_NEG;
			mag = EW'(-err);
		end else begin
			calc.steer_mode = dhb_pkg::STEER_BRAKE;
		end
		if (calc.steer_mode != dhb_pkg::STEER_BRAKE) begin
			if (mag > EW'(dhb_pkg::DUTY_MAX)) begin
				calc.steer_duty = dhb_pkg::DUTY_MAX;
			end else begin
				calc.steer_duty = mag[dhb_pkg::DUTY_W-1:0];
			end
		end

		rev_off = dhb_pkg::SPEED_MID - speed;
		if (speed > dhb_pkg::SPEED_MID) begin
			calc.drive_mode = dhb_pkg::DRIVE_FWD;
			calc.drive_duty = dhb_pkg::DRIVE_DUTY_W'({speed[6:0], 3'b000});
		end else if (speed < dhb_pkg::SPEED_MID) begin
			calc.drive_mode = dhb_pkg::DRIVE_REV;
			calc.drive_duty = dhb_pkg::DRIVE_DUTY_W'({rev_off, 3'b000});
		end else begin
			calc.drive_mode = dhb_pkg::DRIVE_STOP;
			calc.drive_duty = '0;
		end
	end
endmodule

@@ rtl/dhb_state.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bridge state
// Holds speed, modes, duties, PWM counter and pin levels, and applies one
// tick per enabled cycle.
// ----------------------------------------------------------------------------
module dhb_state #(
	parameter int SAMPLE_WIDTH = dhb_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [1:0]                  req_type,
	input  logic [SAMPLE_WIDTH-1:0]     sample,
	input  logic [7:0]                  target,
	input  logic [dhb_pkg::CFG_W-1:0]   deadband,
	input  logic [dhb_pkg::CFG_W-1:0]   pwm_top,
	output dhb_pkg::view_t              view_nxt
);
	logic [dhb_pkg::SPEED_W-1:0]      speed_q, speed_d;
	logic [1:0]                       steer_mode_q, steer_mode_d;
	logic [1:0]                       drive_mode_q, drive_mode_d;
	logic [dhb_pkg::DUTY_W-1:0]       steer_duty_q, steer_duty_d;
	logic [dhb_pkg::DRIVE_DUTY_W-1:0] drive_duty_q, drive_duty_d;
	logic [dhb_pkg::DUTY_W-1:0]       cnt_q, cnt_d;
	logic [3:0]                       pins_q, pins_d;
	logic                             steer_hi;
	logic                             drive_hi;
	dhb_pkg::ctrl_calc_t              calc;

	dhb_ctrl_calc #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_calc (
		.sample     (sample),
		.target     (target),
		.deadband   (deadband),
		.speed      (speed_q),
		.steer_duty (steer_duty_q),
		.calc       (calc)
	);

	// Pin bits: 0 steer A, 1 steer B, 2 drive A, 3 drive B.
	always_comb begin
		speed_d      = speed_q;
		steer_mode_d = steer_mode_q;
		drive_mode_d = drive_mode_q;
		steer_duty_d = steer_duty_q;
		drive_duty_d = drive_duty_q;
		cnt_d        = cnt_q;
		pins_d       = pins_q;
		steer_hi     = 1'b0;
		drive_hi     = 1'b0;
		case (req_type)
			dhb_pkg::REQ_CTRL: begin
				steer_mode_d = calc.steer_mode;
				steer_duty_d = calc.steer_duty;
				drive_mode_d = calc.drive_mode;
				drive_duty_d = calc.drive_duty;
				if (calc.steer_mode == dhb_pkg::STEER_BRAKE) begin
					pins_d[1:0] = 2'b11;
				end else if (calc.steer_mode == dhb_pkg::STEER_POS) begin
					pins_d[1] = 1'b0;
				end else begin
					pins_d[0] = 1'b0;
				end
				if (calc.drive_mode == dhb_pkg::DRIVE_STOP) begin
					pins_d[3:2] = 2'b00;
				end else if (calc.drive_mode == dhb_pkg::DRIVE_FWD) begin
					pins_d[2] = 1'b0;
				end else begin
					pins_d[3] = 1'b0;
				end
			end
			dhb_pkg::REQ_PWM: begin
				cnt_d    = (cnt_q == pwm_top) ? '0 : cnt_q + 1'b1;
				steer_hi = cnt_d > steer_duty_q;
				drive_hi = dhb_pkg::DUTY_W'(drive_duty_q) > cnt_d;
				if (steer_mode_q == dhb_pkg::STEER_POS) begin
					pins_d[0] = steer_hi;
				end else if (steer_mode_q == dhb_pkg::STEER_NEG) begin
					pins_d[1] = steer_hi;
				end
				if (drive_mode_q == dhb_pkg::DRIVE_REV) begin
					pins_d[2] = drive_hi;
				end else if (drive_mode_q == dhb_pkg::DRIVE_FWD) begin
					pins_d[3] = drive_hi;
				end
			end
			dhb_pkg::REQ_RAMP: begin
				if (target > speed_q) begin
					speed_d = speed_q + 1'b1;
				end else if (target < speed_q) begin
					speed_d = speed_q - 1'b1;
				end
			end
			default: begin
			end
		endcase

		view_nxt.steer_pin_a     = pins_d[0];
		view_nxt.steer_pin_b     = pins_d[1];
		view_nxt.drive_pin_a     = pins_d[2];
		view_nxt.drive_pin_b     = pins_d[3];
		view_nxt.steer_direction = steer_mode_d;
		view_nxt.drive_direction = drive_mode_d;
		view_nxt.current_speed   = speed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q      <= dhb_pkg::SPEED_MID;
			steer_mode_q <= dhb_pkg::STEER_POS;
			drive_mode_q <= dhb_pkg::DRIVE_STOP;
			steer_duty_q <= '0;
			drive_duty_q <= '0;
			cnt_q        <= dhb_pkg::PWM_CNT_RST;
			pins_q       <= '0;
		end else if (en) begin
			speed_q      <= speed_d;
			steer_mode_q <= steer_mode_d;
			drive_mode_q <= drive_mode_d;
			steer_duty_q <= steer_duty_d;
			drive_duty_q <= drive_duty_d;
			cnt_q        <= cnt_d;
			pins_q       <= pins_d;
		end
	end
endmodule

@@ rtl/dual_h_bridge_pwm_steer_drive_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual H-bridge PWM steering and drive controller
// Software-style PWM for a steering bridge and a drive bridge.
//
// Requests arrive on the req channel, one tick per transaction: a control
// tick (position sample and steering target), a PWM tick or a speed ramp
// tick (speed target). Every request gives exactly one transaction on the
// res channel with the four bridge pin levels, both directions and the
// ramped speed as they stand after that tick.
// The request is captured in an input register and then applied to the state,
// which loads the result register; one request is taken every cycle while
// res ready stays high. The state update itself is combinational compares
// and a 12-bit counter step.
// If the receiver holds ready low, the result register holds its transaction
// and one further request waits in the input register; req ready then drops.
// Reset clears both channels, sets deadband 100, PWM top 999, counter 500,
// speed 128, steering mode positive, drive stopped and all pins low.
// The configuration port writes deadband (index 0) or PWM top (index 1).
// ----------------------------------------------------------------------------
module dual_h_bridge_pwm_steer_drive_top #(
	parameter int SAMPLE_WIDTH = dhb_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	dhb_req_if.sink                   req,
	dhb_res_if.source                 res,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [dhb_pkg::CFG_W-1:0] cfg_wdata
);
	logic                      vld_s1;
	logic [1:0]                req_type_s1;
	logic [SAMPLE_WIDTH-1:0]   sample_s1;
	logic [7:0]                target_s1;
	logic                      vld_s2;
	dhb_pkg::view_t            view_s2;
	dhb_pkg::view_t            view_nxt;
	logic [dhb_pkg::CFG_W-1:0] deadband_q;
	logic [dhb_pkg::CFG_W-1:0] pwm_top_q;
	logic                      adv;

	assign adv       = vld_s1 && (!vld_s2 || res.ready);
	assign req.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= dhb_pkg::DEADBAND_RST;
			pwm_top_q  <= dhb_pkg::PWM_TOP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dhb_pkg::CFG_DEADBAND: deadband_q <= cfg_wdata;
				dhb_pkg::CFG_PWM_TOP:  pwm_top_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				vld_s1 <= req.valid;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (res.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			sample_s1   <= req.position_sample;
			target_s1   <= req.target_value;
		end
		if (adv) begin
			view_s2 <= view_nxt;
		end
	end

	dhb_state #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.req_type (req_type_s1),
		.sample   (sample_s1),
		.target   (target_s1),
		.deadband (deadband_q),
		.pwm_top  (pwm_top_q),
		.view_nxt (view_nxt)
	);

	assign res.valid           = vld_s2;
	assign res.steer_pin_a     = view_s2.steer_pin_a;
	assign res.steer_pin_b     = view_s2.steer_pin_b;
	assign res.drive_pin_a     = view_s2.drive_pin_a;
	assign res.drive_pin_b     = view_s2.drive_pin_b;
	assign res.steer_direction = view_s2.steer_direction;
	assign res.drive_direction = view_s2.drive_direction;
	assign res.current_speed   = view_s2.current_speed;
endmodule
